@@ hdl/ccr_pkg.sv @@
package ccr_pkg;

   // batch capacity and derived widths
   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_W    = 32;
   localparam int RANK_W     = 6;
   localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W      = IDX_W + 1;

   // popcount tree: groups of compare bits summed in a first stage
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int LT_W       = NUM_GROUPS * GROUP_SIZE;
   localparam int PART_W     = $clog2(GROUP_SIZE + 1);
   localparam int SUM_W      = $clog2(LT_W + 1);

   typedef enum logic [2:0] {
      S_LOAD,
      S_READ,
      S_CMP,
      S_SUM,
      S_OUT
   } ccr_state_type;

   typedef struct packed {
      logic load;   // word accepted on the input channel
      logic rd;     // read key from the value store
      logic cmp;    // compare key against all cells
      logic sum;    // first popcount stage
      logic emit;   // final sum into the output register
   } ccr_cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a rank this cycle
      logic idx_last;   // current key is the last stored value
   } ccr_status_type;

endpackage

@@ hdl/ccr_ctrl.sv @@
module ccr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   input  ccr_pkg::ccr_status_type status,
   output logic                    req_ready,
   output ccr_pkg::ccr_cmd_type    cmd
);
   import ccr_pkg::*;

   ccr_state_type state_ff;
   ccr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.idx_last ? S_LOAD : S_READ;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

@@ hdl/ccr_datapath.sv @@
module ccr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ccr_pkg::ccr_cmd_type           cmd,
   output ccr_pkg::ccr_status_type        status,
   input  logic [ccr_pkg::VALUE_W-1:0]    req_value,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [ccr_pkg::RANK_W-1:0]     rsp_rank,
   output logic                           rsp_last,
   output logic                           rsp_overflow
);
   import ccr_pkg::*;

   logic [VALUE_W-1:0] value_mem [MAX_ITEMS];
   logic [VALUE_W-1:0] cell_ff   [MAX_ITEMS];
   logic [VALUE_W-1:0] key_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               ovf_ff;
   logic [LT_W-1:0]    lt_ff;
   logic [LT_W-1:0]    lt_in;
   logic [PART_W-1:0]  part_ff [NUM_GROUPS];
   logic [SUM_W-1:0]   sum_in;
   logic               full;
   logic               store;
   logic               idx_last;
   logic               rsp_valid_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic               last_ff;
   logic               ovf_out_ff;

   assign full     = (count_ff == CNT_W'(MAX_ITEMS));
   assign store    = cmd.load && !full;
   assign idx_last = ({1'b0, idx_ff} == (count_ff - CNT_W'(1)));

   // value store in arrival order, registered read
   always_ff @(posedge clock) begin
      if (store) begin
         value_mem[count_ff[IDX_W-1:0]] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         key_ff <= value_mem[idx_ff];
      end
   end

   // shift line of compare cells, newest value in cell 0
   always_ff @(posedge clock) begin
      if (store) begin
         cell_ff[0] <= req_value;
         for (int k = 1; k < MAX_ITEMS; k++) begin
            cell_ff[k] <= cell_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (cmd.load) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (cmd.emit) begin
            if (idx_last) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
               idx_ff   <= '0;
            end else begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
      end
   end

   // only cells below the fill count hold values of this batch
   always_comb begin
      lt_in = '0;
      for (int k = 0; k < MAX_ITEMS; k++) begin
         lt_in[k] = (CNT_W'(k) < count_ff) && ($signed(cell_ff[k]) < $signed(key_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp) begin
         lt_ff <= lt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            part_ff[g] <= PART_W'($countones(lt_ff[g*GROUP_SIZE +: GROUP_SIZE]));
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         sum_in = sum_in + SUM_W'(part_ff[g]);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rank_ff    <= sum_in[RANK_W-1:0];
         last_ff    <= idx_last;
         ovf_out_ff <= ovf_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.idx_last = idx_last;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rank     = rank_ff;
   assign rsp_last     = last_ff;
   assign rsp_overflow = ovf_out_ff;

endmodule

@@ hdl/coordinate_compression_rank.sv @@
// Rank compression of a batch of signed 32-bit values. Send the batch one
// word per value on the req_ channel, tlast on the final word. Up to 64 values
// are kept; further values are dropped and every rank of that batch carries
// the overflow flag in rsp_tuser (a dropped final word still closes the
// batch). After the final word the block returns one rank per kept value, in
// arrival order: the count of kept values strictly smaller, so equal values
// share the lowest rank; rsp_tlast marks the last rank of the batch. Values
// load at one per cycle. Each rank then takes a key read from the
// single-port value store, a compare of that key against all stored cells at
// once and two popcount stages, and waits while the output side stalls.
// req_tready is low while ranks are produced; the next batch may start
// loading while the final rank still waits in the output register. No
// clearing pass is needed after reset.
module coordinate_compression_rank (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] rank, [7:6] zero
   output logic        rsp_tlast,   // last_rank
   output logic        rsp_tuser    // [0] overflow
);
   import ccr_pkg::*;

   ccr_cmd_type       cmd;
   ccr_status_type    status;
   logic [RANK_W-1:0] rank;

   // sequencing: load, then read/compare/count/emit per stored value
   ccr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // value store, compare cells, popcount tree and output register
   ccr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_tdata),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_rank     (rank),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_tuser)
   );

   // pad rank to a whole byte
   assign rsp_tdata = {(8 - RANK_W)'(0), rank};

`ifndef SYNTH
   // a final word must start the rank pass on the next cycle
   a_last_starts_rank: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> cmd.rd)
      else $error("rank pass did not start after final word");

   // an emitted rank must show up on the output
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted rank not presented");

   // output valid only rises after an emit
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("output valid without emit");

   // no emit may overwrite a rank that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("rank overwritten while stalled");
`endif

endmodule

@@ sim/tb_coordinate_compression_rank.sv @@
module tb_coordinate_compression_rank;
   import ccr_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_WORDS = 55;
   localparam int HOLD_CYCLES  = 500;
   localparam int SETTLE       = 40;
   localparam int MAX_PRINTS   = 50;

   // one expected rank word, in the order the block must return them
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              last;
      logic              overflow;
   } rank_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] value
   logic        req_tlast;    // last_value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [5:0] rank, [7:6] zero
   logic        rsp_tlast;    // last_rank
   logic        rsp_tuser;    // [0] overflow

   // predictor state: the batch seen so far and whether anything was dropped
   logic signed [VALUE_W-1:0] batch_values[$];
   logic                      batch_dropped;
   rank_word_type             rank_expect_q[$];

   // values of the next batch to send
   logic [31:0] batch_plan[$];

   int error_count;
   int cycle_count;
   int words_sent;
   bit req_gaps_on;
   bit rsp_stalls_on;
   int hold_request;

   coordinate_compression_rank dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // Abort the run if it never drains.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // Mix full-range values with a narrow band (to force ties) and values
   // close to either end of the signed range.
   function automatic logic [31:0] random_value();
      int roll;
      roll = $urandom_range(0, 2);
      if (roll == 0) return $urandom();
      if (roll == 1) return 32'($signed($urandom_range(0, 15)) - 8);
      if ($urandom_range(0, 1) == 1) return 32'h8000_0000 + $urandom_range(0, 3);
      return 32'h7fff_ffff - $urandom_range(0, 3);
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      if (error_count < MAX_PRINTS)
         $display("mismatch %s: got %0d, want %0d (cycle %0d)",
                  field, got, want, cycle_count);
      error_count++;
   endtask

   // Keep the value if there is room, else note the drop. On the final word
   // rank every kept value against the rest and queue one word per value.
   task automatic absorb_value(input logic signed [VALUE_W-1:0] value,
                               input logic last);
      rank_word_type word;
      int            below;
      int            count;
      if (batch_values.size() < MAX_ITEMS)
         batch_values.push_back(value);
      else
         batch_dropped = 1'b1;
      if (last) begin
         count = batch_values.size();
         for (int i = 0; i < count; i++) begin
            below = 0;
            for (int j = 0; j < count; j++)
               if (batch_values[j] < batch_values[i]) below++;
            word.rank     = below[RANK_W-1:0];
            word.last     = (i == count - 1);
            word.overflow = batch_dropped;
            rank_expect_q.push_back(word);
         end
         batch_values.delete();
         batch_dropped = 1'b0;
      end
   endtask

   // Predict from every word the block accepts.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         absorb_value($signed(req_tdata), req_tlast);
   end

   // Compare each accepted rank word with the oldest expectation.
   always @(posedge clock) begin : check_ranks
      rank_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rank_expect_q.size() == 0) begin
            report_mismatch("rank word with nothing pending", rsp_tdata, 0);
         end else begin
            want = rank_expect_q.pop_front();
            if (rsp_tdata !== {{(8 - RANK_W){1'b0}}, want.rank})
               report_mismatch("rank", rsp_tdata, want.rank);
            if (rsp_tlast !== want.last)
               report_mismatch("last_rank", rsp_tlast, want.last);
            if (rsp_tuser !== want.overflow)
               report_mismatch("overflow", rsp_tuser, want.overflow);
         end
      end
   end

   // Receiver: honor a requested hold-off first, then stall at random, or
   // stay ready when stalls are switched off.
   initial begin : drive_rsp_ready
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!rsp_stalls_on) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Offer one word and hold it until accepted. Leave tvalid high so the
   // next word can follow without a bubble.
   task automatic send_word(input logic [31:0] value, input logic last);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Send batch_plan as one batch, tlast on its final word, and clear it.
   task automatic send_plan();
      for (int i = 0; i < batch_plan.size(); i++)
         send_word(batch_plan[i], i == batch_plan.size() - 1);
      batch_plan.delete();
   endtask

   task automatic plan_random(input int count);
      repeat (count) batch_plan.push_back(random_value());
   endtask

   // Batches of one: the rank is always zero, whatever the value.
   task automatic test_single_values();
      batch_plan = '{32'h8000_0000};
      send_plan();
      batch_plan = '{32'h7fff_ffff};
      send_plan();
      batch_plan = '{32'h0000_0000};
      send_plan();
   endtask

   // Both ends of the signed range, zero, minus one, alternating bit
   // patterns and duplicates in one batch.
   task automatic test_extremes_and_ties();
      batch_plan = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                     32'h0000_0001, 32'h8000_0001, 32'haaaa_aaaa, 32'h5555_5555,
                     32'h0000_0000, 32'hffff_ffff};
      send_plan();
   endtask

   // Equal values all share rank zero.
   task automatic test_all_equal();
      batch_plan = '{32'h5a5a_5a5a, 32'h5a5a_5a5a, 32'h5a5a_5a5a, 32'h5a5a_5a5a};
      send_plan();
   endtask

   // Descending order: ranks come back reversed.
   task automatic test_descending();
      batch_plan = '{32'd400, 32'd300, 32'd200, 32'd100, 32'hffff_ff00};
      send_plan();
   endtask

   // Hold the receiver off for a long stretch while an oversized batch loads
   // and the next batch is already being offered: the output side backs up
   // and the block must stall its input. The oversized batch drops its tail,
   // final word included.
   task automatic test_capacity_under_backpressure();
      hold_request = HOLD_CYCLES;
      plan_random(MAX_ITEMS + 2);
      send_plan();
      plan_random(4);
      send_plan();
   endtask

   // No gaps on either side: batches follow each other word after word.
   task automatic test_back_to_back();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      for (int n = 1; n <= 6; n++) begin
         plan_random(n);
         send_plan();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Random batches, mostly small, now and then large enough to overflow.
   task automatic test_random_batches();
      int start;
      int roll;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         roll = $urandom_range(0, 99);
         if (roll < 85)
            plan_random($urandom_range(1, 8));
         else if (roll < 95)
            plan_random($urandom_range(9, 24));
         else
            plan_random($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6));
         send_plan();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      batch_dropped = 1'b0;
      error_count   = 0;
      cycle_count   = 0;
      words_sent    = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      hold_request  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_values();
      test_extremes_and_ties();
      test_all_equal();
      test_descending();
      test_capacity_under_backpressure();
      test_back_to_back();
      test_random_batches();

      // Drop tvalid, drain the ranks still owed, then keep clocking so that any
      // stray word would show.
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rank_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
